@@ hw/rtl/weighted_least_conn_selector_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the weighted least-connections selector
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_LEAST_CONN_SELECTOR_DEFINES_SVH
`define WEIGHTED_LEAST_CONN_SELECTOR_DEFINES_SVH

`define WLC_ASSERT_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("wlc check failed");

`define WLC_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("wlc check failed");

`endif

@@ hw/rtl/wlcs_pkg.sv @@
// ---------------------------------------------------------------------------
// wlcs_pkg
// Types and constants shared by the selector modules.
// ---------------------------------------------------------------------------
package wlcs_pkg;

  localparam logic [1:0] MODE_UPDATE = 2'd0;
  localparam logic [1:0] MODE_OPEN   = 2'd1;
  localparam logic [1:0] MODE_CLOSE  = 2'd2;

  localparam logic CFG_MASK  = 1'b0;
  localparam logic CFG_VALUE = 1'b1;

  localparam int ST_RUNNING = 0;
  localparam int ST_MASTER  = 1;
  localparam int ST_SLAVE   = 2;
  localparam int ST_MAINT   = 5;

  localparam logic [9:0] LOAD_SCALE = 10'd1000;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_WRITE, S_MSCAN, S_CSCAN, S_DIV, S_DIVWAIT, S_CMP, S_BUMP, S_BUMPWR, S_OUT
  } state_t;

  typedef struct packed {
    logic [5:0]  status;
    logic        active;
    logic [9:0]  weight;
    logic [7:0]  depth;
    logic [15:0] cur;
    logic [31:0] total;
  } entry_t;

  function automatic logic is_running(input logic [5:0] s);
    return s[ST_RUNNING] && !s[ST_MAINT];
  endfunction

  function automatic logic is_master(input logic [5:0] s);
    return s[ST_RUNNING] && s[ST_MASTER] && !s[ST_SLAVE] && !s[ST_MAINT];
  endfunction

endpackage

@@ hw/rtl/weighted_least_conn_selector.sv @@
// ---------------------------------------------------------------------------
// weighted_least_conn_selector
// Weighted least-connections backend selector around one entry memory.
// ---------------------------------------------------------------------------
// channel | dir | handshake         | word
// in      | in  | in_valid/in_ready | mode, server_index, status_bits, ...
// out     | out | out_valid/ready   | found, chosen_index, current_count
// cfg     | in  | cfg_valid/ready   | cfg_index, cfg_data
// Update/close: memory read, write back, result.
// Request: master scan over NUM_SERVERS entries, then a candidate scan;
//   the 27-step divider dominates, at most one load per eligible entry.
// Reset: sync; clears NUM_SERVERS entries one per cycle, no item accepted.
// Result is staged, then moved to the output register once it is free;
//   a new word is taken while the previous one still waits.
// ---------------------------------------------------------------------------
module weighted_least_conn_selector #(
  parameter int NUM_SERVERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [3:0]  server_index,
  input  logic [5:0]  status_bits,
  input  logic        entry_active,
  input  logic [9:0]  entry_weight,
  input  logic [7:0]  entry_depth,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [3:0]  chosen_index,
  output logic [15:0] current_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);
  import wlcs_pkg::*;

  localparam int AW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int IW = (AW > 4) ? AW : 4;

  entry_t mem [NUM_SERVERS];
  entry_t rd;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  entry_t        wd;

  logic [IW-1:0] idx_w;
  assign idx_w = IW'(server_index);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wd;
    rd <= mem[raddr];
  end

  logic [4:0] match_mask, match_value;
  always_ff @(posedge clk) begin
    if (rst) begin
      match_mask  <= 5'd1;
      match_value <= 5'd1;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MASK) match_mask <= cfg_data;
      else match_value <= cfg_data;
    end
  end
  assign cfg_ready = 1'b1;

  state_t state, state_next;
  logic        clearing;
  logic [AW:0] clr_cnt;
  logic [AW:0] scan;
  logic        rd_ok;

  logic [1:0]    op_mode;
  logic [AW-1:0] op_idx;
  logic [5:0]    op_st;
  logic          op_act;
  logic [9:0]    op_w;
  logic [7:0]    op_d;

  logic          m_ok;
  logic [AW-1:0] m_idx;
  logic [7:0]    m_depth;
  logic [9:0]    m_w;

  logic          c_ok;
  logic [AW-1:0] c_idx;
  logic [9:0]    c_w;
  logic [31:0]   c_tot;
  logic [26:0]   c_load;

  logic [AW-1:0] e_idx;
  logic [9:0]    e_w;
  logic [31:0]   e_tot;
  logic [15:0]   e_cur;

  logic          res_found;
  logic [3:0]    res_idx;
  logic [15:0]   res_count;

  logic        div_start, div_done;
  logic [26:0] div_q;

  wlcs_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .cur(e_cur), .weight(e_w),
    .done(div_done), .quot(div_q)
  );

  entry_t upd;
  logic [AW-1:0] sel;
  logic          sel_ok;
  logic          elig;
  logic          last;
  logic          out_free;

  always_comb begin
    elig = rd.active && is_running(rd.status) &&
           ((rd.status[4:0] & match_mask & match_value) != 5'd0);
    last = (scan[AW-1:0] == AW'(NUM_SERVERS - 1));
    sel    = c_ok ? c_idx : m_idx;
    sel_ok = c_ok || m_ok;
  end

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && !clearing;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    raddr      = scan[AW-1:0];
    we         = 1'b0;
    waddr      = clr_cnt[AW-1:0];
    wd         = '0;
    div_start  = 1'b0;
    upd        = rd;
    if (clearing) we = 1'b1;
    case (state)
      S_IDLE: begin
        raddr = op_idx;
        if (in_valid && in_ready) begin
          raddr = idx_w[AW-1:0];
          if (mode == MODE_OPEN) begin
            raddr = '0;
            state_next = S_MSCAN;
          end else if ((mode == MODE_UPDATE || mode == MODE_CLOSE) &&
                       ({1'b0, idx_w} < (IW+1)'(NUM_SERVERS))) begin
            state_next = S_RD;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_RD: begin
        raddr = op_idx;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        we    = 1'b1;
        waddr = op_idx;
        if (op_mode == MODE_UPDATE) begin
          upd.status = op_st;
          upd.active = op_act;
          upd.weight = op_w;
          upd.depth  = op_d;
        end else if (rd.cur != 16'd0) begin
          upd.cur = rd.cur - 16'd1;
        end
        wd = upd;
        state_next = S_OUT;
      end
      S_MSCAN: begin
        raddr = rd_ok ? AW'(scan + 1'b1) : scan[AW-1:0];
        if (rd_ok && last) begin
          state_next = S_CSCAN;
          raddr = '0;
        end
      end
      S_CSCAN: begin
        if (rd_ok && elig) begin
          if (m_ok && scan[AW-1:0] == m_idx && match_value[ST_SLAVE]) begin
            state_next = last ? S_BUMP : S_CSCAN;
            raddr = AW'(scan + 1'b1);
          end else if (m_ok && scan[AW-1:0] == m_idx && match_value[ST_MASTER]) begin
            state_next = S_BUMP;
          end else if (!m_ok && match_value[ST_MASTER]) begin
            state_next = S_BUMP;
          end else begin
            state_next = S_DIV;
          end
        end else if (rd_ok) begin
          state_next = last ? S_BUMP : S_CSCAN;
          raddr = AW'(scan + 1'b1);
        end
        if (state_next == S_BUMP) raddr = sel;
      end
      S_DIV: begin
        div_start  = 1'b1;
        state_next = S_DIVWAIT;
      end
      S_DIVWAIT: begin
        if (div_done) state_next = S_CMP;
      end
      S_CMP: begin
        raddr = AW'(scan + 1'b1);
        state_next = last ? S_BUMP : S_CSCAN;
        if (last) raddr = sel;
      end
      S_BUMP: begin
        raddr = sel;
        state_next = sel_ok ? S_BUMPWR : S_OUT;
      end
      S_BUMPWR: begin
        we    = 1'b1;
        waddr = sel;
        if (rd.cur != 16'hFFFF) upd.cur = rd.cur + 16'd1;
        if (rd.total != 32'hFFFF_FFFF) upd.total = rd.total + 32'd1;
        wd = upd;
        state_next = S_OUT;
      end
      S_OUT: state_next = out_free ? S_IDLE : S_OUT;
      default: state_next = S_IDLE;
    endcase
  end

  logic cand_new;
  always_comb begin
    cand_new = 1'b0;
    if (!c_ok) cand_new = 1'b1;
    else if (e_w == 10'd0 || c_w == 10'd0) cand_new = (e_w != 10'd0);
    else if (div_q < c_load || (div_q == c_load && e_tot < c_tot)) cand_new = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      rd_ok     <= 1'b0;
      scan      <= '0;
      m_ok      <= 1'b0;
      c_ok      <= 1'b0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == (AW+1)'(NUM_SERVERS - 1)) clearing <= 1'b0;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      rd_ok <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && in_ready) begin
          op_mode <= mode;  op_idx <= idx_w[AW-1:0];  op_st <= status_bits;
          op_act  <= entry_active;  op_w <= entry_weight;  op_d <= entry_depth;
          scan <= '0;  m_ok <= 1'b0;  c_ok <= 1'b0;  rd_ok <= 1'b1;
          res_found <= 1'b0;  res_count <= '0;
          res_idx <= (mode == MODE_UPDATE || mode == MODE_CLOSE) ? server_index : 4'd0;
        end
        S_WRITE: begin
          res_found <= 1'b1;
          res_count <= upd.cur;
        end
        S_MSCAN: begin
          rd_ok <= 1'b1;
          if (rd_ok) begin
            if (rd.active && is_master(rd.status) &&
                (!m_ok || rd.depth < m_depth || (rd.depth == m_depth && rd.weight > m_w))) begin
              m_ok <= 1'b1;  m_idx <= scan[AW-1:0];
              m_depth <= rd.depth;  m_w <= rd.weight;
            end
            scan <= last ? '0 : scan + 1'b1;
          end
        end
        S_CSCAN: begin
          rd_ok <= 1'b1;
          if (rd_ok) begin
            e_idx <= scan[AW-1:0];  e_w <= rd.weight;
            e_tot <= rd.total;  e_cur <= rd.cur;
            if (state_next == S_BUMP && elig &&
                !(m_ok && scan[AW-1:0] == m_idx && match_value[ST_SLAVE])) begin
              if (m_ok && scan[AW-1:0] == m_idx && match_value[ST_MASTER]) begin
                c_ok <= 1'b1;  c_idx <= m_idx;
              end else begin
                c_ok <= 1'b0;  m_ok <= 1'b0;
              end
            end
            if (state_next == S_CSCAN) scan <= scan + 1'b1;
            else if (state_next == S_BUMP) rd_ok <= 1'b0;
          end
        end
        S_CMP: begin
          if (cand_new) begin
            c_ok <= 1'b1;  c_idx <= e_idx;  c_w <= e_w;  c_tot <= e_tot;
            c_load <= div_q;
          end
          rd_ok <= 1'b1;
          scan  <= scan + 1'b1;
        end
        S_BUMPWR: begin
          res_found <= 1'b1;
          res_idx   <= 4'(sel);
          res_count <= upd.cur;
        end
        default: ;
      endcase
      if (state == S_OUT && out_free) begin
        out_valid     <= 1'b1;
        found         <= res_found;
        chosen_index  <= res_idx;
        current_count <= res_count;
      end
    end
  end

`include "weighted_least_conn_selector_defines.svh"

  `WLC_ASSERT_IMPL(a_no_accept_busy, clk, rst, in_valid && in_ready, state == S_IDLE && !clearing)
  `WLC_ASSERT_NEXT(a_out_follows, clk, rst, state == S_OUT, out_valid)
  `WLC_ASSERT_IMPL(a_no_clear_op, clk, rst, clearing, state == S_IDLE)

endmodule

@@ hw/rtl/wlcs_div.sv @@
// ---------------------------------------------------------------------------
// wlcs_div
// Restoring divider, one quotient bit per cycle: (cur+1)*1000 / weight.
// ---------------------------------------------------------------------------
module wlcs_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] cur,
  input  logic [9:0]  weight,
  output logic        done,
  output logic [26:0] quot
);
  import wlcs_pkg::*;

  localparam int NW = 27;

  logic [NW-1:0] num;
  logic [9:0]    den;
  logic [10:0]   rem;
  logic [4:0]    cnt;
  logic          busy;
  logic [10:0]   trial;
  logic [10:0]   sub;

  assign trial = {rem[9:0], num[NW-1]};
  assign sub   = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(NW - 1);
        rem  <= '0;
        den  <= weight;
        num  <= 27'({1'b0, cur} + 17'd1) * 27'(LOAD_SCALE);
      end else if (busy) begin
        if (!sub[10]) begin
          rem <= sub;
          num <= {num[NW-2:0], 1'b1};
        end else begin
          rem <= trial;
          num <= {num[NW-2:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

  assign quot = num;

endmodule
